// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of the sorter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, held off during reset.
`define ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorter check failed");

// Next-cycle implication, sampled on the rising clock, held off during reset.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorter check failed");

`endif

// File: hdl/ads_pkg.sv
// Shared types and constants of the area-descending sorter.
package ads_pkg;

    // Field widths of input and result items.
    localparam int DIM_W    = 12;
    localparam int AREA_W   = 24;
    localparam int INDEX_W  = 6;

    // Packed stream widths, padded to whole bytes.
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;
    localparam int M_PAD_W  = M_DATA_W - INDEX_W - AREA_W;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One classified item waiting for the insertion chain.
    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic              last;
    } queue_entry_t;

endpackage

// File: hdl/ads_front.sv
// Front end: accepts size items and turns each into an area entry for the queue.
module ads_front
    import ads_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tlast,
    output logic                q_valid,
    input  logic                q_ready,
    output queue_entry_t        q_entry
);

    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [AREA_W-1:0] area;

    // Unpack the width and height fields.
    assign width  = s_tdata[DIM_W-1:0];
    assign height = s_tdata[2*DIM_W-1:DIM_W];

    // A 12 by 12 product fits the 24-bit area exactly; the queue registers it.
    assign area = AREA_W'(width) * AREA_W'(height);

    // Hand the item straight to the queue.
    assign q_valid       = s_tvalid;
    assign s_tready      = q_ready;
    assign q_entry.area  = area;
    assign q_entry.last  = s_tlast;

endmodule

// File: hdl/ads_queue.sv
// Short queue of area entries between the front and the insertion chain.
module ads_queue
    import ads_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  queue_entry_t wr_entry,
    output logic         rd_valid,
    input  logic         rd_ready,
    output queue_entry_t rd_entry
);

    queue_entry_t       mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QPTR_W:0]    fill_reg;
    logic [QPTR_W:0]    fill_next;
    logic               push;
    logic               pop;

    assign wr_ready = (fill_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_entry = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

// File: hdl/ads_back.sv
// Back end: stable insertion chain that keeps areas descending, then drains in order.
module ads_back
    import ads_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  queue_entry_t        q_entry,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic [AREA_W-1:0]  area_reg [MAX_ITEMS];
    logic [INDEX_W-1:0] idx_reg  [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] ge;
    logic [MAX_ITEMS-1:0] ge_prev;

    logic               state_reg;
    logic               state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic               pop;
    logic               insert;
    logic               shift_out;
    logic [INDEX_W-1:0] new_idx;

    assign q_ready   = (state_reg == ST_LOAD);
    assign pop       = q_valid && q_ready;
    assign insert    = pop && (count_reg < CNT_W'(MAX_ITEMS));
    assign m_tvalid  = (state_reg == ST_DRAIN);
    assign shift_out = m_tvalid && m_tready;
    assign new_idx   = INDEX_W'(count_reg);

    // Result fields come straight from the head cell.
    assign m_tdata = {{M_PAD_W{1'b0}}, area_reg[0], idx_reg[0]};
    assign m_tuser = ovf_reg;
    assign m_tlast = (count_reg == CNT_W'(1));

    // Each occupied cell whose area is at least the new one keeps its place.
    always_comb
    begin
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            ge[i] = (CNT_W'(i) < count_reg) && (area_reg[i] >= q_entry.area);
        end
    end
    assign ge_prev = {ge[MAX_ITEMS-2:0], 1'b1};

    // Row of cells: keep, take the new item, or shift down on insert; shift up on drain.
    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        logic [AREA_W-1:0]  above_area;
        logic [INDEX_W-1:0] above_idx;
        logic [AREA_W-1:0]  below_area;
        logic [INDEX_W-1:0] below_idx;

        if (i == 0)
        begin : g_head
            assign above_area = q_entry.area;
            assign above_idx  = new_idx;
        end
        else
        begin : g_body
            assign above_area = area_reg[i-1];
            assign above_idx  = idx_reg[i-1];
        end

        if (i == MAX_ITEMS - 1)
        begin : g_tail
            assign below_area = '0;
            assign below_idx  = '0;
        end
        else
        begin : g_inner
            assign below_area = area_reg[i+1];
            assign below_idx  = idx_reg[i+1];
        end

        always_ff @(posedge clk)
        begin
            if (insert && !ge[i])
            begin
                if (ge_prev[i])
                begin
                    area_reg[i] <= q_entry.area;
                    idx_reg[i]  <= new_idx;
                end
                else
                begin
                    area_reg[i] <= above_area;
                    idx_reg[i]  <= above_idx;
                end
            end
            else if (shift_out)
            begin
                area_reg[i] <= below_area;
                idx_reg[i]  <= below_idx;
            end
        end
    end

    // Load and drain control.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (pop)
                begin
                    if (insert)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (q_entry.last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (shift_out)
                begin
                    count_next = count_reg - 1'b1;
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next = ST_LOAD;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

// File: hdl/area_descending_sorter.sv
// First result: with an empty queue, the last item of a batch is written into the queue,
// then popped into the insertion chain, whose state register turns to draining and shows
// the head cell's result. Throughput: one item per cycle while loading and the queue has room;
// the insertion chain places one queued item per cycle, and a batch drains from the head cell.
// While the chain drains, the four-entry queue keeps taking items until it fills.
// Reset: rst_n is asynchronous and active low; it empties the queue and the batch,
// and clears the overflow flag; stored areas and indexes are not cleared.
module area_descending_sorter
    import ads_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // width [11:0], height [23:12]
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // item_index [5:0], area [29:6], zero [31:30]
    output logic                m_tuser,   // overflowed
    output logic                m_tlast
);

    logic         fq_valid;
    logic         fq_ready;
    queue_entry_t fq_entry;
    logic         qb_valid;
    logic         qb_ready;
    queue_entry_t qb_entry;

    // Accept items and compute their areas.
    ads_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_entry  (fq_entry)
    );

    // Decouple the front from the chain.
    ads_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_entry (fq_entry),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_entry (qb_entry)
    );

    // Sort by insertion and emit the batch.
    ads_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_entry  (qb_entry),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: hdl/ads_checker.sv
// Port-level checks of the sorter's result stream, bound to the top level.
`include "assert_macros.svh"

module ads_checker
    import ads_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tuser,
    input logic                m_tlast
);

    logic               out_acc;
    logic [AREA_W-1:0]  cur_area;
    logic [INDEX_W-1:0] cur_idx;
    logic               run_reg;
    logic [AREA_W-1:0]  prev_area_reg;
    logic [INDEX_W-1:0] prev_idx_reg;
    logic               prev_ovf_reg;

    assign out_acc  = m_tvalid && m_tready;
    assign cur_idx  = m_tdata[INDEX_W-1:0];
    assign cur_area = m_tdata[INDEX_W+AREA_W-1:INDEX_W];

    // Remember the previous result of the current run.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else if (out_acc)
        begin
            run_reg <= !m_tlast;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_acc)
        begin
            prev_area_reg <= cur_area;
            prev_idx_reg  <= cur_idx;
            prev_ovf_reg  <= m_tuser;
        end
    end

    // A shown result waits until it is taken.
    `ASSERT_NEXT(a_hold_valid, clk, rst_n, m_tvalid && !m_tready, m_tvalid)

    // Areas never rise within a run.
    `ASSERT_NOW(a_descending, clk, rst_n, out_acc && run_reg, cur_area <= prev_area_reg)

    // Equal areas come out in arrival order.
    `ASSERT_NOW(a_stable_order, clk, rst_n,
        out_acc && run_reg && (cur_area == prev_area_reg), cur_idx > prev_idx_reg)

    // The overflow flag is the same on every result of a run.
    `ASSERT_NOW(a_same_overflow, clk, rst_n, out_acc && run_reg, m_tuser == prev_ovf_reg)

endmodule

bind area_descending_sorter ads_checker u_ads_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: tb/ads_sort_checker.sv
`timescale 1ns / 100ps
// Checker of the area-descending sorter: ranks accepted items by area and compares each result.
module ads_sort_checker
    import ads_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // width [11:0], height [23:12]
    input  logic                s_tlast,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,   // item_index [5:0], area [29:6], zero [31:30]
    input  logic                m_tuser,   // overflowed
    input  logic                m_tlast,
    output int                  fail_count,
    output int                  backlog,
    output int                  results_checked
);

    // One predicted result of a sorted batch.
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [AREA_W-1:0]  area;
        logic               overflowed;
        logic               final_one;
    } ranked_result_t;

    // Ranking of the batch being loaded, largest area first.
    logic [AREA_W-1:0]  ranked_area  [MAX_ITEMS];
    logic [INDEX_W-1:0] ranked_index [MAX_ITEMS];
    int unsigned        held_count;
    logic               batch_dropped;
    ranked_result_t     sorted_results [$];

    always @(posedge clk or negedge rst_n)
    begin : track
        ranked_result_t     want;
        logic [INDEX_W-1:0] got_index;
        logic [AREA_W-1:0]  got_area;
        logic [AREA_W-1:0]  new_area;
        int unsigned        pos;

        if (!rst_n)
        begin
            held_count      = 0;
            batch_dropped   = 1'b0;
            fail_count      = 0;
            results_checked = 0;
            sorted_results.delete();
            backlog <= 0;
        end
        else
        begin
            // Compare each delivered result with the oldest prediction.
            if (m_tvalid && m_tready)
            begin
                got_index = m_tdata[INDEX_W-1:0];
                got_area  = m_tdata[INDEX_W +: AREA_W];
                if (sorted_results.size() == 0)
                begin
                    $error("unexpected result: item_index %0d, area %0d", got_index, got_area);
                    fail_count++;
                end
                else
                begin
                    want = sorted_results.pop_front();
                    if (got_index !== want.index)
                    begin
                        $error("item_index: expected %0d, actual %0d", want.index, got_index);
                        fail_count++;
                    end
                    if (got_area !== want.area)
                    begin
                        $error("area: expected %0d, actual %0d", want.area, got_area);
                        fail_count++;
                    end
                    if (m_tdata[M_DATA_W-1 -: M_PAD_W] !== '0)
                    begin
                        $error("padding: expected 0, actual %0d", m_tdata[M_DATA_W-1 -: M_PAD_W]);
                        fail_count++;
                    end
                    if (m_tuser !== want.overflowed)
                    begin
                        $error("overflowed: expected %0d, actual %0d", want.overflowed, m_tuser);
                        fail_count++;
                    end
                    if (m_tlast !== want.final_one)
                    begin
                        $error("last_out: expected %0d, actual %0d", want.final_one, m_tlast);
                        fail_count++;
                    end
                    results_checked++;
                end
            end

            // Rank each accepted item within capacity behind every equal or larger area; one beyond it flags the batch.
            if (s_tvalid && s_tready)
            begin
                new_area = AREA_W'(s_tdata[DIM_W-1:0]) * AREA_W'(s_tdata[DIM_W +: DIM_W]);
                if (held_count < MAX_ITEMS)
                begin
                    pos = 0;
                    while (pos < held_count && ranked_area[pos] >= new_area)
                        pos++;
                    for (int unsigned j = held_count; j > pos; j--)
                    begin
                        ranked_area[j]  = ranked_area[j-1];
                        ranked_index[j] = ranked_index[j-1];
                    end
                    ranked_area[pos]  = new_area;
                    ranked_index[pos] = INDEX_W'(held_count);
                    held_count++;
                end
                else
                begin
                    batch_dropped = 1'b1;
                end

                // The last item releases the whole ranking and opens a new batch.
                if (s_tlast)
                begin
                    for (int unsigned k = 0; k < held_count; k++)
                    begin
                        want.index      = ranked_index[k];
                        want.area       = ranked_area[k];
                        want.overflowed = batch_dropped;
                        want.final_one  = (k + 1 == held_count);
                        sorted_results  = {sorted_results, want};
                    end
                    held_count    = 0;
                    batch_dropped = 1'b0;
                end
            end

            backlog <= sorted_results.size();
        end
    end

endmodule

// File: tb/tb_area_descending_sorter.sv
`timescale 1ns / 100ps
// Testbench top of the area-descending sorter: clock, reset, item stimulus and verdict.
module tb_area_descending_sorter;
    import ads_pkg::*;

    localparam int MAX_ITEMS     = 64;
    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_ITEMS  = 88;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_BACKLOG  = 32;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // width [11:0], height [23:12]
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // item_index [5:0], area [29:6], zero [31:30]
    logic                m_tuser;         // overflowed
    logic                m_tlast;

    int fail_count;
    int backlog;
    int results_checked;
    int items_sent       = 0;
    int batches_sent     = 0;
    int overflow_batches = 0;
    int drain_pauses     = 0;
    bit sender_tight     = 1'b0;
    bit long_hold_done   = 1'b0;

    always #6 clk = ~clk;

    area_descending_sorter #(.MAX_ITEMS(MAX_ITEMS)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    ads_sort_checker #(.MAX_ITEMS(MAX_ITEMS)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .backlog         (backlog),
        .results_checked (results_checked)
    );

    // Dimension mix: extremes, tiny values that give equal areas, and full range.
    function automatic logic [DIM_W-1:0] rand_dim();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        if (pick < 4)
            return DIM_W'($urandom_range(0, 4));
        return DIM_W'($urandom_range(0, (1 << DIM_W) - 1));
    endfunction

    // Offer one item after an optional idle gap and hold it until it is taken.
    task automatic send_item(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input logic fin);
        int unsigned pick;
        int unsigned gap;
        pick = $urandom_range(0, 9);
        gap  = (sender_tight || pick < 5) ? 0 :
               (pick < 9) ? $urandom_range(1, 3) : $urandom_range(8, 30);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {h, w};
        s_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (fin)
            batches_sent++;
    endtask

    // One batch of random sizes; a third of the batches are sent back to back.
    task automatic send_random_batch(input int unsigned count);
        sender_tight = ($urandom_range(0, 2) == 0);
        for (int unsigned i = 0; i < count; i++)
            send_item(rand_dim(), rand_dim(), i == count - 1);
        sender_tight = 1'b0;
        if (count > MAX_ITEMS)
            overflow_batches++;
    endtask

    // Stop offering items until every predicted result has been delivered.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        drain_pauses++;
    endtask

    // Result side: random ready runs and stalls, plus one long hold-off on a big backlog.
    initial
    begin : receiver
        int unsigned run;

        wait (rst_n === 1'b1);
        forever
        begin
            if (!long_hold_done && backlog >= HOLD_BACKLOG)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else
            begin
                // A ready run ends early once a big backlog calls for the long hold-off.
                m_tready <= 1'b1;
                run = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 16);
                while (run != 0 && (long_hold_done || backlog < HOLD_BACKLOG))
                begin
                    @(posedge clk);
                    run--;
                end
                if (long_hold_done || backlog < HOLD_BACKLOG)
                begin
                    m_tready <= 1'b0;
                    repeat (($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(1, 3))
                        @(posedge clk);
                end
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin : stimulus
        int unsigned base;
        bit          big_done;

        big_done = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-item batches at both ends of the area range.
        send_item(12'd4095, 12'd4095, 1'b1);
        send_item(12'd0, 12'd0, 1'b1);

        // Zero sides, full-range sides and several equal areas in one batch.
        send_item(12'd4095, 12'd1, 1'b0);
        send_item(12'd0, 12'd4095, 1'b0);
        send_item(12'd2, 12'd3, 1'b0);
        send_item(12'd4095, 12'd4095, 1'b0);
        send_item(12'd3, 12'd2, 1'b0);
        send_item(12'd1, 12'd4095, 1'b0);
        send_item(12'd4095, 12'd0, 1'b0);
        send_item(12'd1, 12'd1, 1'b0);
        send_item(12'd6, 12'd1, 1'b0);
        send_item(12'd0, 12'd0, 1'b1);

        // Rising areas: every item lands at the head of the ranking.
        send_item(12'd1, 12'd1, 1'b0);
        send_item(12'd2, 12'd2, 1'b0);
        send_item(12'd3, 12'd3, 1'b0);
        send_item(12'd64, 12'd64, 1'b0);
        send_item(12'd4095, 12'd4094, 1'b1);

        // Falling areas: every item lands at the tail.
        send_item(12'd4000, 12'd4000, 1'b0);
        send_item(12'd2048, 12'd1024, 1'b0);
        send_item(12'd10, 12'd10, 1'b0);
        send_item(12'd0, 12'd7, 1'b1);
        wait_drained();

        // Random batches, one of them over capacity with its last two items dropped.
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            if (!big_done && items_sent - base >= 20)
            begin
                send_random_batch(MAX_ITEMS + 2);
                // Keep offering items while the receiver holds off, so the queue fills.
                send_random_batch(QUEUE_DEPTH + 4);
                big_done = 1'b1;
            end
            else
            begin
                send_random_batch($urandom_range(1, 8));
                if ($urandom_range(0, 4) == 0)
                    wait_drained();
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d items in %0d batches (%0d over capacity), %0d results checked.",
                 items_sent, batches_sent, overflow_batches, results_checked);
        $display("Receiver held off %0d cycles once; sender waited for a drain %0d times.",
                 LONG_HOLD, drain_pauses);
        if (fail_count == 0)
            $display("[area_descending_sorter] OK");
        else
            $display("[area_descending_sorter] ERROR");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #2_000_000;
        $display("[area_descending_sorter] ERROR");
        $finish;
    end

endmodule
